// ===== rtl/core/qphs_pkg.sv =====
package qphs_pkg;

	// table_size register and the slot_index result field
	localparam int SIZE_W     = 11;
	localparam int SLOT_IDX_W = 10;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;
	localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd2;

	typedef logic [1:0] mark_t;
	typedef logic [1:0] opcode_t;

	localparam mark_t MARK_EMPTY    = 2'd0;
	localparam mark_t MARK_OCCUPIED = 2'd1;
	localparam mark_t MARK_DELETED  = 2'd2;

	localparam opcode_t OP_FIND   = 2'd0;
	localparam opcode_t OP_INSERT = 2'd1;
	localparam opcode_t OP_DELETE = 2'd2;

	// remainder unit retires this many dividend bits per cycle
	localparam int MOD_RADIX_BITS = 4;

endpackage

// ===== rtl/core/qphs_mod.sv =====
module qphs_mod #(
	parameter int ITEM_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ITEM_WIDTH-1:0]        dividend,
	input  logic [qphs_pkg::SIZE_W-1:0]  divisor,
	output logic                         done,
	output logic [qphs_pkg::SIZE_W-1:0]  remainder
);
	import qphs_pkg::*;

	localparam int DIGITS = (ITEM_WIDTH + MOD_RADIX_BITS - 1) / MOD_RADIX_BITS;
	localparam int PAD_W  = DIGITS * MOD_RADIX_BITS;
	localparam int CNT_W  = $clog2(DIGITS);

	logic [PAD_W-1:0]  num_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] rem_n;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	// restoring remainder, one compare and subtract per dividend bit, MSB first
	always_comb begin
		logic [SIZE_W:0] t;
		rem_n = rem_q;
		for (int k = 0; k < MOD_RADIX_BITS; k++) begin
			t = {rem_n, num_q[PAD_W-1-k]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			rem_n = t[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIGITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= PAD_W'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << MOD_RADIX_BITS;
			rem_q <= rem_n;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/quadratic_probe_hash_set.sv =====
// Flow: the home slot remainder retires 4 item bits per cycle, then one probe per cycle runs through
// the slot memory read port (read data registered, next slot precomputed).
// Throughput: one request at a time; a new word is taken while the last result waits.
// Reset: a clearing pass marks all TABLE_DEPTH slots empty, one per cycle, with s_tready low;
// table_size resets to 1021 and may be written during the pass.
module quadratic_probe_hash_set #(
	parameter int TABLE_DEPTH = 1024,
	parameter int ITEM_WIDTH  = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [qphs_pkg::SIZE_W-1:0]          cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// [1:0] opcode, [ITEM_WIDTH+1:2] item, zero fill above
	input  logic [((2+ITEM_WIDTH+7)/8)*8-1:0]    s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] success, [10:1] slot_index, [12:11] slot_state, zero fill above
	output logic [15:0]                          m_tdata
);
	import qphs_pkg::*;

	localparam int ADDR_W = $clog2(TABLE_DEPTH);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_PROBE = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]            state_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [SIZE_W-1:0]     table_size_q;
	logic [SIZE_W-1:0]     s_sat;

	opcode_t               op_q;
	logic [ITEM_WIDTH-1:0] item_q;
	logic [SIZE_W-1:0]     s_q;

	logic                  mod_start;
	logic                  mod_done;
	logic [SIZE_W-1:0]     mod_rem;

	logic [SIZE_W-1:0]     idx_q;
	logic [SIZE_W-1:0]     d_q;
	logic [SIZE_W-1:0]     cnt_q;
	logic [SIZE_W-1:0]     last_q;
	logic [SIZE_W-1:0]     idx_n;
	logic [SIZE_W-1:0]     d_n;
	logic [SIZE_W:0]       idx_sum;
	logic [SIZE_W:0]       d_sum;

	logic                  rd_v_s1;
	logic [SIZE_W-1:0]     rd_idx_s1;
	logic                  rd_last_s1;

	mark_t                 mark_mem_q [TABLE_DEPTH];
	logic [ITEM_WIDTH-1:0] val_mem_q  [TABLE_DEPTH];
	mark_t                 mark_rd_q;
	logic [ITEM_WIDTH-1:0] val_rd_q;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic [ADDR_W-1:0]     wr_addr;
	logic                  mark_we;
	mark_t                 mark_wd;
	logic                  val_we;

	logic                  stop;
	logic                  hit;
	logic                  ok;

	logic                  res_ok_q;
	logic [SIZE_W-1:0]     res_idx_q;
	mark_t                 res_mark_q;

	logic                  out_v_q;
	logic                  out_ok_q;
	logic [SLOT_IDX_W-1:0] out_idx_q;
	mark_t                 out_mark_q;

	qphs_mod #(
		.ITEM_WIDTH(ITEM_WIDTH)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (s_tdata[ITEM_WIDTH+1:2]),
		.divisor  (s_sat),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	// clamp the slot count into 2 .. TABLE_DEPTH
	always_comb begin
		if (table_size_q < SIZE_MIN) begin
			s_sat = SIZE_MIN;
		end else if (32'(table_size_q) > 32'(TABLE_DEPTH)) begin
			s_sat = SIZE_W'(TABLE_DEPTH);
		end else begin
			s_sat = table_size_q;
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign mod_start = s_tvalid && s_tready;

	// next probe: idx += 2i+1, step grows by 2, both kept below S
	assign idx_sum = {1'b0, idx_q} + {1'b0, d_q};
	assign d_sum   = {1'b0, d_q} + (SIZE_W+1)'(2);
	assign idx_n   = (idx_sum >= {1'b0, s_q}) ? SIZE_W'(idx_sum - {1'b0, s_q})
	                                          : idx_sum[SIZE_W-1:0];
	assign d_n     = (d_sum >= {1'b0, s_q}) ? SIZE_W'(d_sum - {1'b0, s_q})
	                                        : d_sum[SIZE_W-1:0];

	assign hit  = (mark_rd_q == MARK_OCCUPIED) && (val_rd_q == item_q);
	assign stop = (state_q == ST_PROBE) && rd_v_s1
	              && ((mark_rd_q != MARK_OCCUPIED) || (val_rd_q == item_q) || rd_last_s1);

	// issue the next read speculatively; drop it once the current probe stops
	assign rd_en   = (state_q == ST_PROBE) && (cnt_q <= last_q) && !stop;
	assign rd_addr = ADDR_W'(idx_q);

	always_comb begin
		ok      = 1'b0;
		mark_we = 1'b0;
		mark_wd = MARK_EMPTY;
		val_we  = 1'b0;
		wr_addr = ADDR_W'(rd_idx_s1);
		if (state_q == ST_CLR) begin
			mark_we = 1'b1;
			wr_addr = clr_q;
		end else if (stop) begin
			unique case (op_q)
				OP_FIND: begin
					ok = hit;
				end
				OP_INSERT: begin
					if (mark_rd_q == MARK_EMPTY || mark_rd_q == MARK_DELETED) begin
						ok      = 1'b1;
						mark_we = 1'b1;
						mark_wd = MARK_OCCUPIED;
						val_we  = 1'b1;
					end
				end
				OP_DELETE: begin
					if (hit) begin
						ok      = 1'b1;
						mark_we = 1'b1;
						mark_wd = MARK_DELETED;
					end
				end
				default: begin
					ok = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem_q[wr_addr] <= mark_wd;
		end
		if (rd_en) begin
			mark_rd_q <= mark_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem_q[wr_addr] <= item_q;
		end
		if (rd_en) begin
			val_rd_q <= val_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_q        <= '0;
			table_size_q <= SIZE_RESET;
			rd_v_s1      <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				table_size_q <= cfg_wdata;
			end
			// the finish step reloads the output word itself
			if (out_v_q && m_tready && state_q != ST_FIN) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (mod_done) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					rd_v_s1 <= rd_en;
					if (stop) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_v_q || m_tready) begin
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mod_start) begin
			op_q   <= s_tdata[1:0];
			item_q <= s_tdata[ITEM_WIDTH+1:2];
			s_q    <= s_sat;
		end
		if (state_q == ST_HASH && mod_done) begin
			idx_q  <= mod_rem;
			d_q    <= SIZE_W'(1);
			cnt_q  <= '0;
			last_q <= SIZE_W'({1'b0, s_q[SIZE_W-1:1]} + SIZE_W'(1));
		end else if (rd_en) begin
			idx_q  <= idx_n;
			d_q    <= d_n;
			cnt_q  <= cnt_q + 1'b1;
		end
		if (rd_en) begin
			rd_idx_s1  <= idx_q;
			rd_last_s1 <= (cnt_q == last_q);
		end
		if (stop) begin
			res_ok_q   <= ok;
			res_idx_q  <= rd_idx_s1;
			res_mark_q <= mark_rd_q;
		end
		if (state_q == ST_FIN && (!out_v_q || m_tready)) begin
			out_ok_q   <= res_ok_q;
			out_idx_q  <= SLOT_IDX_W'(res_idx_q);
			out_mark_q <= res_mark_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'b000, out_mark_q, out_idx_q, out_ok_q};

endmodule
